>>> src/shelf_rectangle_allocator_assert.svh
// Assertion macros for the shelf rectangle allocator.
// Both macros sample on clk_i and stay quiet while rst_ni is low.
`ifndef SHELF_RECTANGLE_ALLOCATOR_ASSERT_SVH
`define SHELF_RECTANGLE_ALLOCATOR_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication.
`define SRA_IMPLIES(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("sra assertion failed");
// Next-cycle implication.
`define SRA_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("sra assertion failed");
`else
`define SRA_IMPLIES(lbl, pre, post)
`define SRA_NEXT(lbl, pre, post)
`endif

`endif

>>> src/sra_pkg.sv
`default_nettype none

package sra_pkg;

  // Defaults for the top-level parameters
  localparam int SRA_MAX_RECTS  = 64;
  localparam int SRA_COORD_BITS = 12;

  // Fixed field widths of the ports
  localparam int FIELD_W    = 13;
  localparam int POS_W      = 12;
  localparam int AREA_OUT_W = 25;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;

  localparam logic [FIELD_W-1:0] ATLAS_RESET = 13'd4096;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_HEIGHT = 2'd1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_PLACED  = 2'd0,
    ST_NO_ROOM = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

endpackage

`default_nettype wire

>>> src/sra_cell.sv
`default_nettype none

// One table entry of the chain. It holds a rectangle and folds it into the
// scan word passing through: rightmost covering edge, lowest covering bottom
// and an overlap flag for the current candidate.
module sra_cell #(
  parameter int CB    = 12,
  parameter int CNT_W = 7,
  parameter int SUM_W = 14,
  parameter int IDX   = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CNT_W-1:0] count_i,
  input  logic [CB:0]      row_i,
  input  logic [CB:0]      cx_i,
  input  logic [SUM_W-1:0] qw_i,
  input  logic [SUM_W-1:0] qh_i,
  input  logic             wr_i,
  input  logic             tok_valid_i,
  input  logic [CB:0]      right_i,
  input  logic [CB:0]      next_i,
  input  logic             hit_i,
  output logic             tok_valid_o,
  output logic [CB:0]      right_o,
  output logic [CB:0]      next_o,
  output logic             hit_o
);

  logic [CB-1:0] x_q, y_q;
  logic [CB:0]   w_q, h_q;

  logic             valid_q;
  logic [CB:0]      right_q, next_q;
  logic             hit_q;
  logic [CB:0]      right_d, next_d;
  logic             hit_d;

  logic             active, covers, apart;
  logic [SUM_W-1:0] x_s, y_s, redge, bottom, row_s, cx_s;

  // Entry geometry on the common compare width
  always_comb begin
    x_s    = SUM_W'(x_q);
    y_s    = SUM_W'(y_q);
    redge  = SUM_W'(x_q) + SUM_W'(w_q);
    bottom = SUM_W'(y_q) + SUM_W'(h_q);
    row_s  = SUM_W'(row_i);
    cx_s   = SUM_W'(cx_i);
  end

  // Fold this entry into the passing word
  always_comb begin
    active = CNT_W'(IDX) < count_i;
    covers = (y_s <= row_s) && (row_s < bottom);
    apart  = (cx_s + qw_i <= x_s) || (cx_s >= redge) ||
             (row_s + qh_i <= y_s) || (row_s >= bottom);
    right_d = right_i;
    next_d  = next_i;
    if (active && covers && (redge > SUM_W'(right_i))) begin
      right_d = redge[CB:0];
    end
    if (active && covers && (bottom < SUM_W'(next_i))) begin
      next_d = bottom[CB:0];
    end
    hit_d = hit_i | (active & ~apart);
  end

  // Hand the word to the neighbor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= tok_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    right_q <= right_d;
    next_q  <= next_d;
    hit_q   <= hit_d;
  end

  // Store a placed rectangle when this entry is the next free one
  always_ff @(posedge clk_i) begin
    if (wr_i && (count_i == CNT_W'(IDX))) begin
      x_q <= cx_i[CB-1:0];
      y_q <= row_i[CB-1:0];
      w_q <= qw_i[CB:0];
      h_q <= qh_i[CB:0];
    end
  end

  assign tok_valid_o = valid_q;
  assign right_o     = right_q;
  assign next_o      = next_q;
  assign hit_o       = hit_q;

endmodule

`default_nettype wire

>>> src/shelf_rectangle_allocator.sv
// Channel    | Direction | Ports                                   | Handshake
// request    | in        | req_width_i, req_height_i               | start & !busy
// result     | out       | status_o, pos_x_o, pos_y_o, free_area_o | result_valid_o
// config     | in        | cfg_index_i, cfg_data_i                 | cfg_valid_i & cfg_ready_o
//
// One request at a time; busy stays high until its result word is shown.
// A full table or a zero-sized request skips the search and goes through
// S_TOTAL and S_FREE to its result word.
// Otherwise each shelf row tried costs one chain pass for the covering edges,
// plus a second pass for the overlap check when the candidate fits the width;
// at most rect_count + 1 rows are tried. The scan word walks the cell chain,
// one cell a cycle. Reset clears the count and used area and sets the atlas
// size to its reset value; no clearing pass.
// The result word lasts one cycle and cannot be stalled.
`default_nettype none

`include "shelf_rectangle_allocator_assert.svh"

module shelf_rectangle_allocator #(
  parameter int MAX_RECTS  = sra_pkg::SRA_MAX_RECTS,
  parameter int COORD_BITS = sra_pkg::SRA_COORD_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [sra_pkg::FIELD_W-1:0]       req_width_i,
  input  logic [sra_pkg::FIELD_W-1:0]       req_height_i,
  output logic                              result_valid_o,
  output logic [sra_pkg::STATUS_W-1:0]      status_o,
  output logic [sra_pkg::POS_W-1:0]         pos_x_o,
  output logic [sra_pkg::POS_W-1:0]         pos_y_o,
  output logic [sra_pkg::AREA_OUT_W-1:0]    free_area_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sra_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [sra_pkg::FIELD_W-1:0]       cfg_data_i
);

  import sra_pkg::*;

  localparam int CB     = COORD_BITS;
  localparam int DIM_W  = CB + 1;
  localparam int CNT_W  = $clog2(MAX_RECTS + 1);
  localparam int SUM_W  = ((FIELD_W > DIM_W) ? FIELD_W : DIM_W) + 1;
  localparam int AREA_W = 2 * DIM_W;
  localparam int PW     = (DIM_W > POS_W) ? DIM_W : POS_W;
  localparam int FW     = (AREA_W > AREA_OUT_W) ? AREA_W : AREA_OUT_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ROW   = 6'b000010,
    S_COVER = 6'b000100,
    S_OVER  = 6'b001000,
    S_TOTAL = 6'b010000,
    S_FREE  = 6'b100000
  } state_e;

  state_e              state_q;
  logic [FIELD_W-1:0]  cfg_w_q, cfg_h_q;
  logic [CNT_W-1:0]    count_q;
  logic [AREA_W-1:0]   used_q, area_q, total_q;
  logic [FIELD_W-1:0]  w_q, h_q;
  logic [DIM_W-1:0]    aw_q, ah_q, row_q, cx_q, next_q;
  logic                launch_q;
  status_e             status_q;
  logic [DIM_W-1:0]    px_q, py_q;

  logic [SUM_W-1:0]    qw, qh, dim_max;
  logic [DIM_W-1:0]    aw_eff, ah_eff;
  logic                accept, tbl_wr, launch;
  logic                row_fits, cand_fits, no_next, at_end;
  logic [FW-1:0]       free_wide;
  logic [PW-1:0]       px_wide, py_wide;

  // Scan word links between cells
  logic                tv [MAX_RECTS+1];
  logic [DIM_W-1:0]    tr [MAX_RECTS+1];
  logic [DIM_W-1:0]    tn [MAX_RECTS+1];
  logic                th [MAX_RECTS+1];

  assign cfg_ready_o = 1'b1;
  assign busy        = (state_q != S_IDLE);
  assign accept      = start && !busy;

  // Clamp the atlas size to the coordinate range
  always_comb begin
    dim_max = SUM_W'(1) << CB;
    aw_eff  = (SUM_W'(cfg_w_q) > dim_max) ? dim_max[DIM_W-1:0] : DIM_W'(cfg_w_q);
    ah_eff  = (SUM_W'(cfg_h_q) > dim_max) ? dim_max[DIM_W-1:0] : DIM_W'(cfg_h_q);
  end

  // Search decisions
  always_comb begin
    qw        = SUM_W'(w_q);
    qh        = SUM_W'(h_q);
    at_end    = tv[MAX_RECTS];
    row_fits  = SUM_W'(row_q) + qh <= SUM_W'(ah_q);
    cand_fits = SUM_W'(tr[MAX_RECTS]) + qw <= SUM_W'(aw_q);
    no_next   = (state_q == S_COVER) ? (tn[MAX_RECTS] >= ah_q) : (next_q >= ah_q);
    tbl_wr    = (state_q == S_OVER) && at_end && !th[MAX_RECTS];
    launch    = ((state_q == S_ROW) && row_fits) ||
                ((state_q == S_COVER) && at_end && cand_fits);
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= ATLAS_RESET;
      cfg_h_q <= ATLAS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_ATLAS_WIDTH) begin
        cfg_w_q <= cfg_data_i;
      end
      if (cfg_index_i == CFG_ATLAS_HEIGHT) begin
        cfg_h_q <= cfg_data_i;
      end
    end
  end

  // Control: state, table count, used area, launch and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      count_q        <= '0;
      used_q         <= '0;
      launch_q       <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      launch_q       <= launch;
      result_valid_o <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (count_q == CNT_W'(MAX_RECTS)) begin
              state_q <= S_TOTAL;
            end else if ((req_width_i == '0) || (req_height_i == '0)) begin
              state_q <= S_TOTAL;
            end else begin
              state_q <= S_ROW;
            end
          end
        end
        S_ROW: begin
          state_q <= row_fits ? S_COVER : S_TOTAL;
        end
        S_COVER: begin
          if (at_end) begin
            if (cand_fits) begin
              state_q <= S_OVER;
            end else begin
              state_q <= no_next ? S_TOTAL : S_ROW;
            end
          end
        end
        S_OVER: begin
          if (at_end) begin
            if (tbl_wr) begin
              count_q <= count_q + CNT_W'(1);
              used_q  <= used_q + area_q;
              state_q <= S_TOTAL;
            end else begin
              state_q <= no_next ? S_TOTAL : S_ROW;
            end
          end
        end
        S_TOTAL: begin
          state_q <= S_FREE;
        end
        S_FREE: begin
          result_valid_o <= 1'b1;
          state_q        <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath: request, search position and result fields
  always_ff @(posedge clk_i) begin
    area_q <= AREA_W'(w_q) * AREA_W'(h_q);
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          w_q      <= req_width_i;
          h_q      <= req_height_i;
          aw_q     <= aw_eff;
          ah_q     <= ah_eff;
          row_q    <= '0;
          px_q     <= '0;
          py_q     <= '0;
          status_q <= (count_q == CNT_W'(MAX_RECTS)) ? ST_FULL : ST_NO_ROOM;
        end
      end
      S_COVER: begin
        if (at_end) begin
          next_q <= tn[MAX_RECTS];
          cx_q   <= tr[MAX_RECTS];
          if (!cand_fits) begin
            row_q <= tn[MAX_RECTS];
          end
        end
      end
      S_OVER: begin
        if (tbl_wr) begin
          status_q <= ST_PLACED;
          px_q     <= cx_q;
          py_q     <= row_q;
        end else if (at_end) begin
          row_q <= next_q;
        end
      end
      S_TOTAL: begin
        total_q <= AREA_W'(aw_q) * AREA_W'(ah_q);
      end
      default: begin
      end
    endcase
  end

  // Free area saturates at zero; positions and area drop to port widths
  always_comb begin
    free_wide = (total_q > used_q) ? FW'(total_q - used_q) : '0;
    px_wide   = PW'(px_q);
    py_wide   = PW'(py_q);
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_FREE) begin
      status_o    <= status_q;
      pos_x_o     <= px_wide[POS_W-1:0];
      pos_y_o     <= py_wide[POS_W-1:0];
      free_area_o <= free_wide[AREA_OUT_W-1:0];
    end
  end

  // Head of the chain: a fresh scan word
  assign tv[0] = launch_q;
  assign tr[0] = '0;
  assign tn[0] = ah_q;
  assign th[0] = 1'b0;

  for (genvar i = 0; i < MAX_RECTS; i++) begin : g_cell
    sra_cell #(
      .CB    (CB),
      .CNT_W (CNT_W),
      .SUM_W (SUM_W),
      .IDX   (i)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .count_i     (count_q),
      .row_i       (row_q),
      .cx_i        (cx_q),
      .qw_i        (qw),
      .qh_i        (qh),
      .wr_i        (tbl_wr),
      .tok_valid_i (tv[i]),
      .right_i     (tr[i]),
      .next_i      (tn[i]),
      .hit_i       (th[i]),
      .tok_valid_o (tv[i+1]),
      .right_o     (tr[i+1]),
      .next_o      (tn[i+1]),
      .hit_o       (th[i+1])
    );
  end

  `SRA_NEXT(a_accept_busy, accept, busy)
  `SRA_IMPLIES(a_strobe_idle, result_valid_o, !busy)
  `SRA_NEXT(a_write_count, tbl_wr, count_q == $past(count_q) + CNT_W'(1))
  `SRA_IMPLIES(a_word_in_scan, tv[MAX_RECTS], state_q == S_COVER || state_q == S_OVER)
  `SRA_IMPLIES(a_placed_count, result_valid_o && status_o == ST_PLACED, count_q != '0)

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import sra_pkg::*;

  localparam int          MAX_RECTS = SRA_MAX_RECTS;
  localparam int unsigned DIM_MAX   = 1 << SRA_COORD_BITS;

  typedef struct {
    logic [FIELD_W-1:0] w;
    logic [FIELD_W-1:0] h;
  } alloc_req_t;

  typedef struct {
    status_e               status;
    logic [POS_W-1:0]      pos_x;
    logic [POS_W-1:0]      pos_y;
    logic [AREA_OUT_W-1:0] free_area;
  } alloc_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                 start       = 1'b0;
  logic [FIELD_W-1:0]   req_width   = '0;
  logic [FIELD_W-1:0]   req_height  = '0;
  logic                 cfg_valid   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index   = CFG_ATLAS_WIDTH;
  logic [FIELD_W-1:0]   cfg_data    = '0;

  logic                  busy;
  logic                  result_valid;
  logic [STATUS_W-1:0]   status;
  logic [POS_W-1:0]      pos_x;
  logic [POS_W-1:0]      pos_y;
  logic [AREA_OUT_W-1:0] free_area;
  logic                  cfg_ready;

  // Pending requests and predicted answers
  alloc_req_t    pending_q[$];
  alloc_result_t answer_q[$];
  logic          req_taken = 1'b0;
  int            gap_pct   = 17;

  // Shadow of the atlas: size registers, placed rectangles, used area
  logic [FIELD_W-1:0] atlas_w_cfg = ATLAS_RESET;
  logic [FIELD_W-1:0] atlas_h_cfg = ATLAS_RESET;
  int unsigned        placed_x[MAX_RECTS];
  int unsigned        placed_y[MAX_RECTS];
  int unsigned        placed_w[MAX_RECTS];
  int unsigned        placed_h[MAX_RECTS];
  int                 placed_cnt = 0;
  longint unsigned    area_taken = 0;

  int mismatch_cnt = 0;
  int n_placed     = 0;
  int n_no_room    = 0;
  int n_full       = 0;
  int cfg_writes   = 0;

  shelf_rectangle_allocator dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start          (start),
    .busy           (busy),
    .req_width_i    (req_width),
    .req_height_i   (req_height),
    .result_valid_o (result_valid),
    .status_o       (status),
    .pos_x_o        (pos_x),
    .pos_y_o        (pos_y),
    .free_area_o    (free_area),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always #5 clk = ~clk;

  // Place one request in the shadow atlas and return the answer it should get
  function automatic alloc_result_t place_request(int unsigned w, int unsigned h);
    alloc_result_t   res;
    int unsigned     aw, ah, row, right, nxt, bottom;
    longint unsigned total, spare;
    bit              searching, clear;
    int              i;
    res.status = ST_NO_ROOM;
    res.pos_x  = '0;
    res.pos_y  = '0;
    aw = (atlas_w_cfg > DIM_MAX) ? DIM_MAX : atlas_w_cfg;
    ah = (atlas_h_cfg > DIM_MAX) ? DIM_MAX : atlas_h_cfg;
    if (placed_cnt >= MAX_RECTS) begin
      res.status = ST_FULL;
    end else if (w != 0 && h != 0) begin
      row       = 0;
      searching = 1'b1;
      while (searching && row + h <= ah) begin
        // find the rightmost edge on this shelf row
        right = 0;
        for (i = 0; i < placed_cnt; i++)
          if (placed_y[i] <= row && row < placed_y[i] + placed_h[i] &&
              placed_x[i] + placed_w[i] > right)
            right = placed_x[i] + placed_w[i];
        // candidate must stay inside and clear of every stored rectangle
        clear = (right + w <= aw) && (row + h <= ah);
        for (i = 0; clear && i < placed_cnt; i++)
          if (!(right + w <= placed_x[i] || right >= placed_x[i] + placed_w[i] ||
                row + h <= placed_y[i] || row >= placed_y[i] + placed_h[i]))
            clear = 1'b0;
        if (clear) begin
          placed_x[placed_cnt] = right;
          placed_y[placed_cnt] = row;
          placed_w[placed_cnt] = w;
          placed_h[placed_cnt] = h;
          placed_cnt++;
          area_taken += longint'(w) * h;
          res.status = ST_PLACED;
          res.pos_x  = right[POS_W-1:0];
          res.pos_y  = row[POS_W-1:0];
          searching  = 1'b0;
        end else begin
          // jump to the lowest bottom edge covering this row
          nxt = ah;
          for (i = 0; i < placed_cnt; i++) begin
            bottom = placed_y[i] + placed_h[i];
            if (placed_y[i] <= row && bottom > row && bottom < nxt)
              nxt = bottom;
          end
          if (nxt >= ah) searching = 1'b0;
          else row = nxt;
        end
      end
    end
    total = longint'(aw) * ah;
    spare = (total > area_taken) ? total - area_taken : 0;
    res.free_area = spare[AREA_OUT_W-1:0];
    case (res.status)
      ST_PLACED: n_placed++;
      ST_FULL:   n_full++;
      default:   n_no_room++;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string field, input longint unsigned got,
                                 input longint unsigned want);
    mismatch_cnt++;
    if (mismatch_cnt <= 40)
      $display("[%0t] %s: got %0d, expected %0d", $realtime, field, got, want);
  endtask

  function automatic void push_request(int unsigned w, int unsigned h);
    alloc_req_t req;
    req.w = w[FIELD_W-1:0];
    req.h = h[FIELD_W-1:0];
    pending_q.insert(pending_q.size(), req);
  endfunction

  function automatic logic [FIELD_W-1:0] pick_atlas_dim();
    case ($urandom_range(5))
      0:       return ATLAS_RESET;
      1:       return 13'h1FFF;
      2:       return FIELD_W'($urandom_range(1, 4096));
      3:       return FIELD_W'($urandom_range(1, 64));
      4:       return FIELD_W'($urandom_range(4097, 8191));
      default: return FIELD_W'($urandom_range(512, 4096));
    endcase
  endfunction

  // Hold off until every request has been answered and the block settles
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_q.size() != 0 || answer_q.size() != 0 || start);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_atlas_reg(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [FIELD_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  // Request driver: advance on acceptance, idle at random between words
  always @(negedge clk) begin
    alloc_req_t nxt_req;
    if (rst_n && (!start || req_taken)) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
        nxt_req    = pending_q.pop_front();
        start      <= 1'b1;
        req_width  <= nxt_req.w;
        req_height <= nxt_req.h;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check result words, predict accepted requests, track config
  always @(posedge clk) begin
    alloc_result_t want;
    req_taken <= rst_n && start && !busy;
    if (rst_n) begin
      if (result_valid) begin
        if (answer_q.size() == 0) begin
          report_mismatch("result word with nothing expected, status", status, 0);
        end else begin
          want = answer_q.pop_front();
          if (status !== want.status) report_mismatch("status", status, want.status);
          if (pos_x !== want.pos_x) report_mismatch("pos_x", pos_x, want.pos_x);
          if (pos_y !== want.pos_y) report_mismatch("pos_y", pos_y, want.pos_y);
          if (free_area !== want.free_area)
            report_mismatch("free_area", free_area, want.free_area);
        end
      end
      if (start && !busy)
        answer_q.insert(answer_q.size(), place_request(req_width, req_height));
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_ATLAS_WIDTH) atlas_w_cfg = cfg_data;
        else if (cfg_index == CFG_ATLAS_HEIGHT) atlas_h_cfg = cfg_data;
      end
    end
  end

  // Stimulus
  initial begin
    int          phase, k, pick;
    int unsigned base_w, base_h, w, h;
    logic [FIELD_W-1:0] dim_w, dim_h;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Zero-sized, oversized and exact-fit requests on the reset atlas
    push_request(0, 7);
    push_request(7, 0);
    push_request(0, 0);
    push_request(8191, 8191);
    push_request(4097, 1);
    push_request(1, 4097);
    push_request(4096, 1);
    push_request(1, 1);
    push_request(4095, 2);
    push_request(100, 50);
    push_request(4096, 4093);
    wait_drained();

    // Zero atlas: nothing fits
    write_atlas_reg(CFG_ATLAS_WIDTH, '0);
    push_request(1, 1);
    wait_drained();
    write_atlas_reg(CFG_ATLAS_HEIGHT, '0);
    push_request(1, 1);
    push_request(4096, 4096);
    wait_drained();

    // Oversized registers act as the largest atlas
    write_atlas_reg(CFG_ATLAS_WIDTH, 13'h1FFF);
    write_atlas_reg(CFG_ATLAS_HEIGHT, 13'h1FFF);
    push_request(1, 1);
    push_request(4096, 4096);
    wait_drained();

    // Shrunken atlas below the stored rectangles: free area saturates
    write_atlas_reg(CFG_ATLAS_WIDTH, 13'd1);
    write_atlas_reg(CFG_ATLAS_HEIGHT, 13'd1);
    push_request(1, 1);
    push_request(2, 1);
    wait_drained();

    // Random phases, each on a fresh atlas size
    for (phase = 0; phase < 10; phase++) begin
      dim_w = pick_atlas_dim();
      dim_h = pick_atlas_dim();
      write_atlas_reg(CFG_ATLAS_WIDTH, dim_w);
      write_atlas_reg(CFG_ATLAS_HEIGHT, dim_h);
      base_w  = (dim_w > DIM_MAX) ? DIM_MAX : dim_w;
      base_h  = (dim_h > DIM_MAX) ? DIM_MAX : dim_h;
      gap_pct = (phase == 3) ? 0 : 17;
      for (k = 0; k < 48; k++) begin
        pick = $urandom_range(99);
        if (pick < 4) begin
          // zero-sized in one dimension
          w = $urandom_range(0, 8191);
          h = $urandom_range(0, 8191);
          if ($urandom_range(1)) w = 0;
          else h = 0;
        end else if (pick < 16) begin
          // small enough to fit where there is room
          w = $urandom_range(1, (base_w < 4) ? 1 : base_w / 4);
          h = $urandom_range(1, (base_h < 4) ? 1 : base_h / 4);
        end else if (pick < 28) begin
          w = $urandom_range(0, 8191);
          h = $urandom_range(0, 8191);
        end else if ($urandom_range(1)) begin
          // wide request, forces the search down the shelves
          w = $urandom_range(base_w / 2 + 1, 8191);
          h = $urandom_range(1, (base_h < 8) ? 1 : base_h / 8);
        end else begin
          w = $urandom_range(1, (base_w < 8) ? 1 : base_w / 8);
          h = $urandom_range(base_h / 2 + 1, 8191);
        end
        push_request(w, h);
      end
      wait_drained();
    end
    gap_pct = 17;

    // Fill the table to the end and run past it
    write_atlas_reg(CFG_ATLAS_WIDTH, ATLAS_RESET);
    write_atlas_reg(CFG_ATLAS_HEIGHT, ATLAS_RESET);
    for (k = 0; k < MAX_RECTS - placed_cnt + 4; k++)
      push_request(1, 1);
    wait_drained();
    push_request(4096, 4096);
    push_request(0, 0);
    wait_drained();

    $display("Ran %0d requests: %0d placed, %0d with no room, %0d against a full table",
             n_placed + n_no_room + n_full, n_placed, n_no_room, n_full);
    $display("Atlas size written %0d times, zero, one-texel and oversized sizes included",
             cfg_writes);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #200_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
